[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising clock edge and is held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/atcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcm_pkg
// Types, command text table and defaults for the command line matcher.
// ----------------------------------------------------------------------------
package atcm_pkg;

	typedef logic [7:0] byte_t;

	localparam int DEF_LINE_CAPACITY = 256;
	localparam int DEF_NUM_COMMANDS  = 11;
	localparam int DEF_MAX_CMD_LEN   = 20;

	localparam int KNOWN_CMDS   = 11;
	localparam int CMD_TEXT_LEN = 20;
	localparam int IDX_W        = 4;
	localparam int TIMEOUT_W    = 16;

	localparam byte_t BYTE_CR = 8'h0D;
	localparam byte_t BYTE_LF = 8'h0A;
	localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RESET = 16'd100;

	typedef enum logic {
		MODE_BYTE = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t mode;
		byte_t rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] command_index;
		logic             unknown_command;
	} out_word_t;

	// strobes from the line control to the match bank
	typedef struct packed {
		logic store;
		logic clear;
	} match_ctl_t;

	// command strings, ASCII, zero padded
	localparam byte_t CMD_TEXT [KNOWN_CMDS][CMD_TEXT_LEN] = '{
		'{8'h41, 8'h54, 8'h5E, 8'h48, 8'h45, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h54, 8'h45, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h57, 8'h32, 8'h35, 8'h51, 8'h36, 8'h34, 8'h5F,
		  8'h45, 8'h72, 8'h61, 8'h73, 8'h65, 8'h43, 8'h68, 8'h69, 8'h70, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h4C,
		  8'h69, 8'h73, 8'h74, 8'h44, 8'h69, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h44,
		  8'h65, 8'h6C, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h4D,
		  8'h4F, 8'h55, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h46,
		  8'h4F, 8'h52, 8'h4D, 8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h57,
		  8'h52, 8'h49, 8'h54, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h52,
		  8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h43,
		  8'h6C, 8'h75, 8'h57, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h5E, 8'h46, 8'h41, 8'h54, 8'h46, 8'h53, 8'h5F, 8'h47,
		  8'h65, 8'h74, 8'h54, 8'h69, 8'h6D, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam int CMD_STRLEN [KNOWN_CMDS] = '{7, 7, 19, 16, 16, 14, 15, 14, 13, 17, 16};

	// effective command length: cut to max_cmd_len - 1, empty past the known table
	function automatic int cmd_len(input int k, input int num_commands, input int max_cmd_len);
		int n;
		n = 0;
		if (k < KNOWN_CMDS && k < num_commands) begin
			n = (CMD_STRLEN[k] < max_cmd_len - 1) ? CMD_STRLEN[k] : max_cmd_len - 1;
		end
		return n;
	endfunction

	function automatic byte_t cmd_char(input int k, input logic [5:0] pos);
		byte_t c;
		c = 8'h00;
		if (k < KNOWN_CMDS && int'(pos) < CMD_TEXT_LEN) begin
			c = CMD_TEXT[k][pos[4:0]];
		end
		return c;
	endfunction

endpackage

[hw/rtl/atcm_match_bank.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// atcm_match_bank
// One prefix match flag per command, updated per stored byte, and the
// first-hit selection used at dispatch.
// ----------------------------------------------------------------------------
module atcm_match_bank #(
	parameter int NUM_COMMANDS = atcm_pkg::DEF_NUM_COMMANDS,
	parameter int MAX_CMD_LEN  = atcm_pkg::DEF_MAX_CMD_LEN,
	parameter int CW           = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  atcm_pkg::match_ctl_t    ctl,
	input  atcm_pkg::byte_t         rx_byte,
	input  logic [CW-1:0]           line_count,
	output logic                    hit_found,
	output logic [atcm_pkg::IDX_W-1:0] hit_index
);
	import atcm_pkg::*;

	// wide enough for both the line count and any command length
	localparam int XW = (CW > 7) ? CW : 7;

	logic [NUM_COMMANDS-1:0] still_matching_q;
	logic [NUM_COMMANDS-1:0] keep;
	logic [NUM_COMMANDS-1:0] hit_vec;
	logic [XW-1:0]           count_ext;

	assign count_ext = XW'(line_count);

	for (genvar k = 0; k < NUM_COMMANDS; k++) begin : g_cmd
		localparam int LEN = cmd_len(k, NUM_COMMANDS, MAX_CMD_LEN);
		logic in_range;
		assign in_range = count_ext < XW'(LEN);
		assign keep[k]    = !(in_range && (cmd_char(k, count_ext[5:0]) != rx_byte));
		assign hit_vec[k] = (LEN > 0) && (count_ext >= XW'(LEN)) && still_matching_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_matching_q <= '1;
		end else if (ctl.clear) begin
			still_matching_q <= '1;
		end else if (ctl.store) begin
			still_matching_q <= still_matching_q & keep;
		end
	end

	// lowest table position wins
	always_comb begin
		hit_found = 1'b0;
		hit_index = '0;
		for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				hit_found = 1'b1;
				hit_index = IDX_W'(k);
			end
		end
	end

	`ASSERT_NEXT(a_clear_sets_all, clk, arst_n, ctl.clear, still_matching_q == '1, "match flags not restored on clear")
	`ASSERT_ALWAYS(a_hit_known, clk, arst_n, !hit_found || (int'(hit_index) < KNOWN_CMDS), "hit on an empty command slot")

endmodule

[hw/rtl/atcm_line_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// atcm_line_ctrl
// Line length, close flag and idle tick tracking; decides dispatch.
// ----------------------------------------------------------------------------
module atcm_line_ctrl #(
	parameter int LINE_CAPACITY = atcm_pkg::DEF_LINE_CAPACITY,
	parameter int CW            = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  atcm_pkg::in_word_t                word,
	input  logic [atcm_pkg::TIMEOUT_W-1:0]    idle_timeout,
	output logic [CW-1:0]                     line_count,
	output atcm_pkg::match_ctl_t              ctl,
	output logic                              dispatch
);
	import atcm_pkg::*;

	logic [CW-1:0]        count_q, count_nxt;
	logic                 closed_q, closed_nxt;
	logic [TIMEOUT_W-1:0] idle_q, idle_nxt, idle_tmp;
	logic [CW-1:0]        last_q, last_nxt;
	logic                 can_store;

	assign line_count = count_q;
	assign can_store  = (count_q < CW'(LINE_CAPACITY)) && !closed_q;

	always_comb begin
		count_nxt  = count_q;
		closed_nxt = closed_q;
		idle_nxt   = idle_q;
		last_nxt   = last_q;
		idle_tmp   = idle_q;
		ctl        = '0;
		dispatch   = 1'b0;
		if (step) begin
			unique case (word.mode)
				MODE_BYTE: begin
					if (can_store) begin
						count_nxt = count_q + 1'b1;
						ctl.store = 1'b1;
					end
					if (count_nxt >= CW'(LINE_CAPACITY) || word.rx_byte == BYTE_CR ||
							word.rx_byte == BYTE_LF) begin
						closed_nxt = 1'b1;
					end
				end
				MODE_TICK: begin
					if (!closed_q && count_q == '0) begin
						idle_nxt = '0;
						last_nxt = '0;
					end else begin
						if (count_q > last_q) begin
							last_nxt = count_q;
							idle_tmp = '0;
						end else if (idle_q != '1) begin
							idle_tmp = idle_q + 1'b1;
						end
						idle_nxt = idle_tmp;
						if (idle_tmp >= idle_timeout || closed_q) begin
							dispatch   = 1'b1;
							ctl.clear  = 1'b1;
							count_nxt  = '0;
							closed_nxt = 1'b0;
							idle_nxt   = '0;
							last_nxt   = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b0;
			idle_q   <= '0;
			last_q   <= '0;
		end else begin
			count_q  <= count_nxt;
			closed_q <= closed_nxt;
			idle_q   <= idle_nxt;
			last_q   <= last_nxt;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(LINE_CAPACITY), "line count beyond capacity")
	`ASSERT_ALWAYS(a_closed_nonempty, clk, arst_n, !closed_q || count_q != '0, "closed line with no bytes")
	`ASSERT_ALWAYS(a_no_store_closed, clk, arst_n, !ctl.store || !closed_q, "byte stored on a closed line")

endmodule

[hw/rtl/at_command_line_matcher_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// at_command_line_matcher_core
// Serial command line collector and command prefix matcher.
// ----------------------------------------------------------------------------
// Takes one word per cycle while not stalled (a received byte or a poll tick)
// and returns one result on each tick that dispatches a line: the table
// position of the first command that prefixes the line, or the unknown flag.
// A word passes through an input register, then the line and match state
// update and any result lands in the output register. A tick waits in the
// input register and its result is registered when the tick advances.
// With the output free, words can follow back to back. While a result is
// held by a stall the word in the input register waits, whatever it is,
// and the input stalls until the result is taken.
// There is no line buffer and no clearing pass after reset.
module at_command_line_matcher_core #(
	parameter int LINE_CAPACITY = atcm_pkg::DEF_LINE_CAPACITY,
	parameter int NUM_COMMANDS  = atcm_pkg::DEF_NUM_COMMANDS,
	parameter int MAX_CMD_LEN   = atcm_pkg::DEF_MAX_CMD_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  atcm_pkg::in_word_t             item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output atcm_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [atcm_pkg::TIMEOUT_W-1:0] cfg_data
);
	import atcm_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY + 1);

	in_word_t             item_s1;
	logic                 valid_s1;
	out_word_t            result_s2;
	logic                 result_valid_s2;
	logic [TIMEOUT_W-1:0] idle_timeout_q;
	logic                 adv;
	logic                 dispatch;
	logic                 hit_found;
	logic [IDX_W-1:0]     hit_index;
	logic [CW-1:0]        line_count;
	match_ctl_t           ctl;

	assign adv          = valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !adv;
	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			idle_timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (adv && dispatch) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dispatch) begin
			result_s2.command_index   <= hit_found ? hit_index : '0;
			result_s2.unknown_command <= !hit_found;
		end
	end

	atcm_line_ctrl #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.CW            (CW)
	) u_line_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.word         (item_s1),
		.idle_timeout (idle_timeout_q),
		.line_count   (line_count),
		.ctl          (ctl),
		.dispatch     (dispatch)
	);

	atcm_match_bank #(
		.NUM_COMMANDS (NUM_COMMANDS),
		.MAX_CMD_LEN  (MAX_CMD_LEN),
		.CW           (CW)
	) u_match_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rx_byte    (item_s1.rx_byte),
		.line_count (line_count),
		.hit_found  (hit_found),
		.hit_index  (hit_index)
	);

	`ASSERT_ALWAYS(a_unknown_index_zero, clk, arst_n,
		!result_valid_s2 || !result_s2.unknown_command || result_s2.command_index == '0,
		"unknown line with nonzero index")
	`ASSERT_ALWAYS(a_dispatch_only_tick, clk, arst_n,
		!dispatch || item_s1.mode == MODE_TICK, "dispatch on a byte word")
	`ASSERT_NEXT(a_pending_result_kept, clk, arst_n, result_valid_s2 && result_stall,
		result_valid_s2, "stalled result dropped")

endmodule
